FILE: rtl/core/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

    // window size register, fixed by the register map
    localparam int WS_W = 7;
    localparam logic [WS_W-1:0] WS_RESET = 7'd3;

    // fill state of the result buffer
    typedef struct packed {
        logic out_full;
        logic skid_full;
    } swm_buf_stat_t;

endpackage

FILE: rtl/core/swm_cell.sv
`timescale 1ns / 1ps
// One cell of the running-maximum chain: max of the samples aged 0 up to its index.
module swm_cell
    import swm_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] sample,
    input  logic signed [W-1:0] prev_max,
    output logic signed [W-1:0] max_reg
);

    logic signed [W-1:0] max_next;

    always_comb
    begin
        max_next = (sample > prev_max) ? sample : prev_max;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg <= max_next;
        end
    end

endmodule

FILE: rtl/core/swm_obuf.sv
`timescale 1ns / 1ps
// Output register with a skid stage for result words.
module swm_obuf
    import swm_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic signed [W-1:0] push_data,
    input  logic                result_stall,
    output logic                result_valid,
    output logic signed [W-1:0] result_data,
    output swm_buf_stat_t       stat
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic signed [W-1:0] out_data_reg;
    logic signed [W-1:0] out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic signed [W-1:0] skid_data_reg;
    logic signed [W-1:0] skid_data_next;
    logic                take;

    always_comb
    begin
        take            = out_valid_reg && !result_stall;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input is stalled; drain the skid word once the front is taken
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid   = out_valid_reg;
    assign result_data    = out_data_reg;
    assign stat.out_full  = out_valid_reg;
    assign stat.skid_full = skid_valid_reg;

endmodule

FILE: rtl/core/sliding_window_maximum.sv
`timescale 1ns / 1ps
// Top level of the sliding window maximum block.
//
//  channel  dir  handshake                   payload
//  sample   in   sample_valid/sample_stall   sample, restart
//  result   out  result_valid/result_stall   window_max
//  config   in   window_size_wr_en           window_size_wr_data
//
// One sample word is taken per clock unless sample_stall is high. Once the window fills,
// each result word is registered. Every cell updates its max on each accepted sample.
// Reset clears the counters and the result buffer and loads a window size of three.
// A stalled result is held in the output register; one more result fits in the skid
// stage, and sample input stalls only while that stage is occupied.
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_size_wr_en,
    input  logic [WS_W-1:0]                window_size_wr_data,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           restart,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW    = (CNT_W > WS_W) ? CNT_W : WS_W;

    logic [WS_W-1:0]    ws_reg;
    logic [CNT_W-1:0]   live_reg;
    logic [CNT_W-1:0]   live_next;
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   seen_next;
    logic [KW-1:0]      ws_ext;
    logic [KW-1:0]      k_sel;
    logic [CNT_W-1:0]   k;
    logic [CNT_W-1:0]   live_base;
    logic [CNT_W-1:0]   seen_base;
    logic [CNT_W:0]     live_inc;
    logic [IDX_W-1:0]   tap_idx;
    logic               accept;
    logic               emit;
    logic signed [SAMPLE_WIDTH-1:0] tap_max;
    logic signed [SAMPLE_WIDTH-1:0] res_max;
    logic signed [SAMPLE_WIDTH-1:0] chain_max [WINDOW_MAX];
    swm_buf_stat_t      buf_stat;

    assign sample_stall = buf_stat.skid_full;
    assign accept       = sample_valid && !sample_stall;

    // clamp the window to the chain length
    always_comb
    begin
        ws_ext = KW'(ws_reg);
        k_sel  = (ws_ext > KW'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : ws_ext;
        k      = CNT_W'(k_sel);
    end

    // live: samples still retained; drop the oldest once the window passes them
    always_comb
    begin
        live_base = restart ? '0 : live_reg;
        seen_base = restart ? '0 : seen_reg;
        live_inc  = {1'b0, live_base} + (CNT_W+1)'(1);
        if (k == '0)
        begin
            live_next = CNT_W'(1);
        end
        else if (live_inc > {1'b0, k})
        begin
            live_next = k;
        end
        else
        begin
            live_next = CNT_W'(live_inc);
        end
        if (seen_base == CNT_W'(WINDOW_MAX))
        begin
            seen_next = seen_base;
        end
        else
        begin
            seen_next = seen_base + CNT_W'(1);
        end
        emit = (k != '0) && (seen_next >= k);
    end

    // chain of running maxima: cell i holds the max of the samples aged 0..i
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                swm_cell #(.W(SAMPLE_WIDTH)) u_cell (
                    .clk      (clk),
                    .en       (accept),
                    .sample   (sample),
                    .prev_max (sample),
                    .max_reg  (chain_max[gi])
                );
            end
            else
            begin : g_body
                swm_cell #(.W(SAMPLE_WIDTH)) u_cell (
                    .clk      (clk),
                    .en       (accept),
                    .sample   (sample),
                    .prev_max (chain_max[gi-1]),
                    .max_reg  (chain_max[gi])
                );
            end
        end
    endgenerate

    // tap the chain one cell short of the live length and fold in the new sample
    always_comb
    begin
        tap_idx = IDX_W'(live_next - CNT_W'(2));
        tap_max = chain_max[tap_idx];
        if (live_next == CNT_W'(1))
        begin
            res_max = sample;
        end
        else
        begin
            res_max = (sample > tap_max) ? sample : tap_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= WS_RESET;
            live_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            if (window_size_wr_en)
            begin
                ws_reg <= window_size_wr_data;
            end
            if (accept)
            begin
                live_reg <= live_next;
                seen_reg <= seen_next;
            end
        end
    end

    swm_obuf #(.W(SAMPLE_WIDTH)) u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && emit),
        .push_data    (res_max),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (window_max),
        .stat         (buf_stat)
    );

    a_live_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= seen_reg)
        else $error("retained count exceeds samples seen");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        buf_stat.skid_full |-> buf_stat.out_full)
        else $error("skid stage full while output register empty");

    a_restart_one_live: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (live_reg == CNT_W'(1)) && (seen_reg == CNT_W'(1)))
        else $error("restart did not reopen the window");

    a_no_result_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (ws_reg == '0) && !buf_stat.out_full) |=> !result_valid)
        else $error("result produced with a window size of zero");

endmodule

FILE: tb/sv/sliding_window_maximum_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sliding window maximum block.
module sliding_window_maximum_test;
    import swm_pkg::*;

    localparam int WMAX        = 64;
    localparam int SW          = 32;
    localparam int AGE_SAT     = 127;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 window_size_wr_en;
    logic [WS_W-1:0]      window_size_wr_data;
    logic                 sample_valid;
    logic                 sample_stall;
    logic signed [SW-1:0] sample;
    logic                 restart;
    logic                 result_valid;
    logic                 result_stall;
    logic signed [SW-1:0] window_max;

    // tracked copy of the block's state
    logic [WS_W-1:0]      win_size;
    logic signed [SW-1:0] cand_val [WMAX];
    logic [6:0]           cand_age [WMAX];
    int                   cand_cnt;
    int                   seen_cnt;

    logic signed [SW-1:0] max_expected [$];
    int                   fail_count;
    int                   quiet_cycles;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    sliding_window_maximum uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .window_size_wr_en   (window_size_wr_en),
        .window_size_wr_data (window_size_wr_data),
        .sample_valid        (sample_valid),
        .sample_stall        (sample_stall),
        .sample              (sample),
        .restart             (restart),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .window_max          (window_max)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Update the candidate queue with one sample and tell whether a maximum comes out.
    task automatic advance_window(input logic signed [SW-1:0] s, input logic r,
                                  output bit fire, output logic signed [SW-1:0] mx);
        int k;
        int drop;
        int i;
        k = (win_size > WMAX) ? WMAX : int'(win_size);
        if (r)
        begin
            cand_cnt = 0;
            seen_cnt = 0;
        end
        for (i = 0; i < cand_cnt; i++)
            if (cand_age[i] < AGE_SAT)
                cand_age[i]++;
        // drop candidates that have left the window
        drop = 0;
        while (drop < cand_cnt && int'(cand_age[drop]) >= k)
            drop++;
        if (drop > 0)
        begin
            for (i = 0; i + drop < cand_cnt; i++)
            begin
                cand_val[i] = cand_val[i + drop];
                cand_age[i] = cand_age[i + drop];
            end
            cand_cnt -= drop;
        end
        // pop smaller candidates from the back; equal ones stay
        while (cand_cnt > 0 && s > cand_val[cand_cnt - 1])
            cand_cnt--;
        if (cand_cnt < WMAX)
        begin
            cand_val[cand_cnt] = s;
            cand_age[cand_cnt] = '0;
            cand_cnt++;
        end
        if (seen_cnt < WMAX)
            seen_cnt++;
        fire = !(k == 0 || seen_cnt < k);
        mx = cand_val[0];
    endtask

    // Input and output handshakes, both taken at the same edge.
    always @(posedge clk)
    begin : word_monitor
        bit                   fire;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                advance_window(sample, restart, fire, mx);
                if (fire)
                    max_expected.insert(max_expected.size(), mx);
            end
            if (result_valid && !result_stall)
            begin
                if (max_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected window_max word %0d", window_max);
                end
                else
                begin
                    want = max_expected[0];
                    max_expected.delete(0);
                    if (window_max !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("window_max mismatch: expected %0d, got %0d",
                                     want, window_max);
                    end
                end
            end
        end
    end

    always @(posedge clk)
        result_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || window_size_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("sliding_window_maximum_test: errors");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] s, input logic r);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        restart      <= r;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Hold off input until every pending maximum has come out.
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (max_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_window(input logic [WS_W-1:0] ws);
        window_size_wr_en   <= 1'b1;
        window_size_wr_data <= ws;
        @(posedge clk);
        win_size = ws;
        window_size_wr_en <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 10)) - 5;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WS_W-1:0] pick_window();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 7'd64;
            2:       return 7'd65;
            3:       return 7'd127;
            4:       return WS_W'($urandom_range(9, 63));
            5:       return 7'd1;
            default: return WS_W'($urandom_range(2, 8));
        endcase
    endfunction

    // No restart after reset, default window of three.
    task automatic test_default_window();
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd7, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sd0, 1'b0);
    endtask

    task automatic test_extreme_samples();
        drain_results();
        write_window(7'd1);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b0);
    endtask

    task automatic test_window_zero();
        drain_results();
        write_window(7'd0);
        send_sample(32'sd11, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(-32'sd3, 1'b0);
    endtask

    task automatic test_short_sequence();
        drain_results();
        write_window(7'd4);
        send_sample(32'sd1, 1'b1);
        send_sample(32'sd2, 1'b0);
        send_sample(32'sd3, 1'b1);
        send_sample(32'sd4, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd6, 1'b0);
    endtask

    // Equal values kept; window shrinks and then grows mid-sequence.
    task automatic test_resize_mid_sequence();
        drain_results();
        write_window(7'd4);
        send_sample(32'sd9, 1'b1);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd1, 1'b0);
        drain_results();
        write_window(7'd2);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd2, 1'b0);
        drain_results();
        write_window(7'd6);
        send_sample(32'sd4, 1'b0);
    endtask

    task automatic test_random_sequences(input int n_items);
        int sent;
        int seg_sent;
        int seg_len;
        int k;
        int len;
        int j;
        bit cont;
        logic r;
        sent = 0;
        while (sent < n_items)
        begin
            drain_results();
            write_window(pick_window());
            k = (win_size > WMAX) ? WMAX : int'(win_size);
            seg_len = $urandom_range(40, 120);
            if (seg_len > n_items - sent)
                seg_len = n_items - sent;
            cont = 1'($urandom_range(0, 1));
            seg_sent = 0;
            while (seg_sent < seg_len)
            begin
                if (k == 0)
                    len = $urandom_range(1, 8);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, k);
                else
                    len = k + $urandom_range(0, 2 * k + 4);
                for (j = 0; j < len; j++)
                begin
                    if (j == 0)
                        r = !cont;
                    else
                        r = ($urandom_range(0, 49) == 0);
                    send_sample(pick_sample(), r);
                end
                cont = 1'b0;
                seg_sent += len;
            end
            sent += seg_sent;
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        window_size_wr_en   <= 1'b0;
        window_size_wr_data <= '0;
        sample_valid        <= 1'b0;
        sample              <= '0;
        restart             <= 1'b0;
        result_stall        <= 1'b0;
        win_size     = WS_RESET;
        cand_cnt     = 0;
        seen_cnt     = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 58;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_extreme_samples();
        test_window_zero();
        test_short_sequence();
        test_resize_mid_sequence();
        test_random_sequences(480);
        send_idle_pct = 58;
        recv_idle_pct = 37;
        test_random_sequences(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(490);

        drain_results();
        repeat (8) @(posedge clk);
        if (max_expected.size() != 0)
            fail_count += max_expected.size();
        if (fail_count == 0)
            $display("sliding_window_maximum_test: clean");
        else
            $display("sliding_window_maximum_test: errors");
        $finish;
    end

endmodule
